/* hw/rtl/bkrb_pkg.sv */
`default_nettype none

package bkrb_pkg;

    localparam int STORE_DEPTH_DEF = 64;

    localparam int KEY_W       = 16;
    localparam int ACT_W       = 2;
    localparam int BUF_START_W = 6;
    localparam int BUF_END_W   = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 7;

    localparam logic [BUF_END_W-1:0] BUF_END_RST = 7'd16;

    // input actions
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_PEEK  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_STORE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_NONE  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REG_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_END   = 2'd1;

    // translation constants
    localparam logic [15:0] KEY_E0_PLAIN     = 16'h00e0;
    localparam logic [7:0]  CH_EXT           = 8'he0;
    localparam logic [7:0]  SC_ALT_AT        = 8'h23;
    localparam logic [7:0]  SC_DITCH_MIN     = 8'h85;
    localparam logic [15:0] KEY_KP_SLASH     = 16'he02f;
    localparam logic [15:0] KEY_KP_SLASH_OLD = 16'h352f;
    localparam logic [15:0] KEY_KP_ENTER     = 16'he00d;
    localparam logic [15:0] KEY_KP_CTL_ENTER = 16'he00a;
    localparam logic [7:0]  SC_ENTER         = 8'h1c;
    localparam logic [7:0]  SC_KP_MINUS      = 8'h4a;
    localparam logic [7:0]  SC_KP_PLUS       = 8'h4e;
    localparam logic [7:0]  SC_KP_STAR       = 8'h37;

    typedef struct packed {
        logic              ok;
        logic [KEY_W-1:0]  key;
    } xlat_t;

    typedef struct packed {
        logic item_load;
        logic store_do;
        logic res_none;
        logic res_empty;
        logic eval_do;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic busy;
        logic ring_empty;
        logic steps_done;
        logic key_ok;
    } dp_status_t;

    // Map a key to the old keyboard's codes; ok low means drop the key.
    function automatic xlat_t key_translate(input logic [KEY_W-1:0] key);
        xlat_t      r;
        logic [7:0] sc;
        logic [7:0] ch;
        logic       ditch_list;
        sc = key[15:8];
        ch = key[7:0];
        ditch_list = (sc == 8'h01) || (sc == 8'h0e) ||
                     (sc >= 8'h1a && sc <= SC_ENTER) ||
                     (sc >= 8'h27 && sc <= 8'h29) || (sc == 8'h2b) ||
                     (sc >= 8'h33 && sc <= 8'h35) || (sc == SC_KP_STAR) ||
                     (sc == SC_KP_MINUS) || (sc == 8'h4c) || (sc == SC_KP_PLUS);
        r.ok  = 1'b1;
        r.key = key;
        if (key == KEY_E0_PLAIN) begin
            r.key = key;
        end else if (ch == CH_EXT) begin
            if (sc == SC_ALT_AT) begin
                r.key = KEY_E0_PLAIN;
            end else if (sc >= SC_DITCH_MIN) begin
                r.ok = 1'b0;
            end else begin
                r.key = {sc, 8'h00};
            end
        end else if (ch == 8'h00 && ditch_list) begin
            r.ok = 1'b0;
        end else if (key == KEY_KP_SLASH) begin
            r.key = KEY_KP_SLASH_OLD;
        end else if (key == KEY_KP_ENTER || key == KEY_KP_CTL_ENTER) begin
            r.key = {SC_ENTER, ch};
        end else if (sc >= SC_DITCH_MIN) begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/bios_keyboard_ring_buffer.sv */
// Keyboard ring buffer of 16-bit key words with BIOS-style read, peek and store.
// Input channel (s_valid/s_ready): one item carries an action, the extended flag and a
// key code. Every item gives exactly one result on the m_ channel (m_valid/m_ready):
// the head key for a read or peek, an empty flag, a refused store's full flag, or zeros.
// Configuration channel (cfg_valid/cfg_ready): index 0 writes the ring start, index 1
// the wrap point; write only while no item is in flight.
// Sequence: an unused action goes straight to the output state; a store passes through
// the store state; a read or peek alternates a fetch state and an evaluate state,
// going round again for each ditched key that is skipped (up to STORE_DEPTH of
// them). The skip walk reads the key store through its single registered read port;
// one item is worked on at a time, and the next item is taken once the control is
// back in idle after the result is loaded.
// The result sits in an output register: the next item is accepted while it waits,
// and a stalled receiver only blocks that item's completion.
// Reset: head and tail at entry 0, start 0, wrap point 16; key store contents undefined.
// After a start write the input is held off while the start is reduced modulo the
// store depth.
`default_nettype none

module bios_keyboard_ring_buffer #(
    parameter int STORE_DEPTH = bkrb_pkg::STORE_DEPTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [bkrb_pkg::ACT_W-1:0]        s_action,
    input  wire logic                              s_extended,
    input  wire logic [bkrb_pkg::KEY_W-1:0]        s_key_code,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic      [bkrb_pkg::KEY_W-1:0]        m_key_out,
    output logic                                   m_empty_res,
    output logic                                   m_full_res,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [bkrb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bkrb_pkg::CFG_DATA_W-1:0]   cfg_data
);

    bkrb_pkg::ctrl_cmd_t  cmd;
    bkrb_pkg::dp_status_t status;
    logic                 cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    bkrb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .status   (status),
        .cmd      (cmd)
    );

    bkrb_dpath #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .s_action    (s_action),
        .s_extended  (s_extended),
        .s_key_code  (s_key_code),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .m_key_out   (m_key_out),
        .m_empty_res (m_empty_res),
        .m_full_res  (m_full_res)
    );

    a_empty_no_key: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_empty_res |-> (m_key_out == '0) && !m_full_res)
        else $error("empty result carries a key or a full flag");

    a_full_no_key: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_full_res |-> (m_key_out == '0))
        else $error("refused store carries a key");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is still being worked on");

endmodule

`default_nettype wire

/* hw/rtl/bkrb_ram.sv */
`default_nettype none

module bkrb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hw/rtl/bkrb_ctrl.sv */
`default_nettype none

module bkrb_ctrl (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [bkrb_pkg::ACT_W-1:0]   s_action,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    input  wire bkrb_pkg::dp_status_t         status,
    output bkrb_pkg::ctrl_cmd_t               cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_STORE = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_EVAL  = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       accept;
    logic       out_free;

    assign s_ready  = (state_reg == ST_IDLE) && !status.busy;
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.item_load = 1'b1;
                    priority if (s_action == bkrb_pkg::ACT_STORE) begin
                        state_next = ST_STORE;
                    end else if (s_action == bkrb_pkg::ACT_NONE) begin
                        cmd.res_none = 1'b1;
                        state_next   = ST_OUT;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_STORE: begin
                cmd.store_do = 1'b1;
                state_next   = ST_OUT;
            end
            ST_READ: begin
                // head entry is fetched this cycle; give up on empty or skip bound
                if (status.ring_empty || status.steps_done) begin
                    cmd.res_empty = 1'b1;
                    state_next    = ST_OUT;
                end else begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.eval_do = 1'b1;
                state_next  = status.key_ok ? ST_OUT : ST_READ;
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

/* hw/rtl/bkrb_dpath.sv */
`default_nettype none

module bkrb_dpath #(
    parameter int STORE_DEPTH = bkrb_pkg::STORE_DEPTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire bkrb_pkg::ctrl_cmd_t               cmd,
    output bkrb_pkg::dp_status_t                   status,
    input  wire logic [bkrb_pkg::ACT_W-1:0]        s_action,
    input  wire logic                              s_extended,
    input  wire logic [bkrb_pkg::KEY_W-1:0]        s_key_code,
    input  wire logic                              cfg_we,
    input  wire logic [bkrb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bkrb_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic      [bkrb_pkg::KEY_W-1:0]        m_key_out,
    output logic                                   m_empty_res,
    output logic                                   m_full_res
);

    localparam int PW = $clog2(STORE_DEPTH);
    localparam int CW = (PW + 1 > bkrb_pkg::BUF_END_W) ? PW + 1 : bkrb_pkg::BUF_END_W;
    localparam int SW = (PW + 1 > bkrb_pkg::BUF_START_W) ? PW + 1 : bkrb_pkg::BUF_START_W;
    localparam logic [CW-1:0] DEPTH_C   = CW'(STORE_DEPTH);
    localparam logic [SW-1:0] DEPTH_S   = SW'(STORE_DEPTH);
    localparam logic [PW:0]   STEPS_MAX = (PW + 1)'(STORE_DEPTH);

    localparam int KW = bkrb_pkg::KEY_W;

    logic [SW-1:0]                     start_work_reg, start_work_next;
    logic [bkrb_pkg::BUF_END_W-1:0]    end_reg, end_next;
    logic [PW-1:0]                     head_reg, head_next;
    logic [PW-1:0]                     tail_reg, tail_next;
    logic [PW:0]                       steps_reg, steps_next;
    logic [bkrb_pkg::ACT_W-1:0]        act_reg, act_next;
    logic                              ext_reg, ext_next;
    logic [KW-1:0]                     code_reg, code_next;
    logic [KW-1:0]                     res_key_reg, res_key_next;
    logic                              res_empty_reg, res_empty_next;
    logic                              res_full_reg, res_full_next;
    logic [KW-1:0]                     out_key_reg, out_key_next;
    logic                              out_empty_reg, out_empty_next;
    logic                              out_full_reg, out_full_next;

    logic                              start_busy;
    logic [PW-1:0]                     start_mod;
    logic [PW-1:0]                     head_adv;
    logic [PW-1:0]                     tail_adv;
    logic                              ring_full;
    logic                              ram_we;
    logic [KW-1:0]                     ram_rdata;
    bkrb_pkg::xlat_t                   xl;
    logic                              key_ok;
    logic [KW-1:0]                     key_sel;

    function automatic logic [PW-1:0] ring_next(
        input logic [PW-1:0]                  p,
        input logic [bkrb_pkg::BUF_END_W-1:0] e,
        input logic [PW-1:0]                  s
    );
        logic [CW-1:0] n;
        n = CW'(p) + CW'(1);
        if (n == CW'(e)) begin
            return s;
        end else if (n >= DEPTH_C) begin
            return '0;
        end
        return n[PW-1:0];
    endfunction

    // start is reduced modulo the store depth by repeated subtraction
    assign start_busy = (start_work_reg >= DEPTH_S);
    assign start_mod  = start_work_reg[PW-1:0];

    assign head_adv  = ring_next(head_reg, end_reg, start_mod);
    assign tail_adv  = ring_next(tail_reg, end_reg, start_mod);
    assign ring_full = (tail_adv == head_reg);
    assign ram_we    = cmd.store_do && !ring_full;

    bkrb_ram #(
        .WIDTH (KW),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (code_reg),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    assign xl      = bkrb_pkg::key_translate(ram_rdata);
    assign key_ok  = ext_reg || xl.ok;
    assign key_sel = ext_reg ? ram_rdata : xl.key;

    assign status.busy       = start_busy;
    assign status.ring_empty = (head_reg == tail_reg);
    assign status.steps_done = (steps_reg == STEPS_MAX);
    assign status.key_ok     = key_ok;

    always_comb begin
        start_work_next = start_work_reg;
        end_next        = end_reg;
        if (start_busy) begin
            start_work_next = start_work_reg - DEPTH_S;
        end
        if (cfg_we) begin
            if (cfg_index == bkrb_pkg::CFG_REG_START) begin
                start_work_next = SW'(cfg_data[bkrb_pkg::BUF_START_W-1:0]);
            end else if (cfg_index == bkrb_pkg::CFG_REG_END) begin
                end_next = cfg_data[bkrb_pkg::BUF_END_W-1:0];
            end
        end
    end

    always_comb begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        steps_next     = steps_reg;
        act_next       = act_reg;
        ext_next       = ext_reg;
        code_next      = code_reg;
        res_key_next   = res_key_reg;
        res_empty_next = res_empty_reg;
        res_full_next  = res_full_reg;
        out_key_next   = out_key_reg;
        out_empty_next = out_empty_reg;
        out_full_next  = out_full_reg;

        if (cmd.item_load) begin
            act_next   = s_action;
            ext_next   = s_extended;
            code_next  = s_key_code;
            steps_next = '0;
        end
        if (cmd.res_none) begin
            res_key_next   = '0;
            res_empty_next = 1'b0;
            res_full_next  = 1'b0;
        end
        if (cmd.store_do) begin
            res_key_next   = '0;
            res_empty_next = 1'b0;
            res_full_next  = ring_full;
            if (!ring_full) begin
                tail_next = tail_adv;
            end
        end
        if (cmd.res_empty) begin
            res_key_next   = '0;
            res_empty_next = 1'b1;
            res_full_next  = 1'b0;
        end
        if (cmd.eval_do) begin
            if (key_ok) begin
                res_key_next   = key_sel;
                res_empty_next = 1'b0;
                res_full_next  = 1'b0;
                if (act_reg == bkrb_pkg::ACT_READ) begin
                    head_next = head_adv;
                end
            end else begin
                // drop the ditched key and move on
                head_next  = head_adv;
                steps_next = steps_reg + (PW + 1)'(1);
            end
        end
        if (cmd.out_load) begin
            out_key_next   = res_key_reg;
            out_empty_next = res_empty_reg;
            out_full_next  = res_full_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_work_reg <= '0;
            end_reg        <= bkrb_pkg::BUF_END_RST;
            head_reg       <= '0;
            tail_reg       <= '0;
            steps_reg      <= '0;
        end else begin
            start_work_reg <= start_work_next;
            end_reg        <= end_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            steps_reg      <= steps_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg       <= act_next;
        ext_reg       <= ext_next;
        code_reg      <= code_next;
        res_key_reg   <= res_key_next;
        res_empty_reg <= res_empty_next;
        res_full_reg  <= res_full_next;
        out_key_reg   <= out_key_next;
        out_empty_reg <= out_empty_next;
        out_full_reg  <= out_full_next;
    end

    assign m_key_out   = out_key_reg;
    assign m_empty_res = out_empty_reg;
    assign m_full_res  = out_full_reg;

endmodule

`default_nettype wire

/* tb/sv/tb_bios_keyboard_ring_buffer.sv */
module tb_bios_keyboard_ring_buffer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KB_DEPTH = bkrb_pkg::STORE_DEPTH_DEF;

    typedef struct packed {
        logic [bkrb_pkg::ACT_W-1:0] action;
        logic                       extended;
        logic [bkrb_pkg::KEY_W-1:0] key_code;
    } key_req_t;

    typedef struct packed {
        logic [bkrb_pkg::KEY_W-1:0] key_out;
        logic                       empty_res;
        logic                       full_res;
    } kb_result_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic [bkrb_pkg::ACT_W-1:0]      s_action = bkrb_pkg::ACT_NONE;
    logic                            s_extended = 1'b0;
    logic [bkrb_pkg::KEY_W-1:0]      s_key_code = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic [bkrb_pkg::KEY_W-1:0]      m_key_out;
    logic                            m_empty_res;
    logic                            m_full_res;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [bkrb_pkg::CFG_IDX_W-1:0]  cfg_index = bkrb_pkg::CFG_REG_START;
    logic [bkrb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // shadow of the ring: contents, which entries hold a stored key, pointers, bounds
    logic [bkrb_pkg::KEY_W-1:0] kb_words [KB_DEPTH];
    bit                         kb_written [KB_DEPTH];
    int                         kb_head;
    int                         kb_tail;
    int                         kb_start;
    int                         kb_end;

    key_req_t   key_reqs [$];
    kb_result_t answers_due [$];

    bit in_taken = 1'b0;
    bit calm = 1'b0;
    int gap_left = 0;
    int stall_left = 0;
    int mism = 0;
    int results_seen = 0;

    bios_keyboard_ring_buffer uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_extended  (s_extended),
        .s_key_code  (s_key_code),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_key_out   (m_key_out),
        .m_empty_res (m_empty_res),
        .m_full_res  (m_full_res),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    function automatic int kb_next(int p);
        int n;
        n = p + 1;
        if (n == kb_end) return kb_start % KB_DEPTH;
        if (n >= KB_DEPTH) return 0;
        return n;
    endfunction

    // old-keyboard mapping used by the non-extended service; ok low drops the key
    function automatic bkrb_pkg::xlat_t legacy_key(logic [bkrb_pkg::KEY_W-1:0] raw);
        bkrb_pkg::xlat_t x;
        logic [7:0]      sc;
        logic [7:0]      ch;
        bit              dropped_scan;
        sc = raw[15:8];
        ch = raw[7:0];
        x.ok = 1'b1;
        x.key = raw;
        case (sc)
            8'h01, 8'h0e, 8'h1a, 8'h1b, 8'h1c, 8'h27, 8'h28, 8'h29, 8'h2b,
            8'h33, 8'h34, 8'h35, 8'h37, 8'h4a, 8'h4c, 8'h4e: dropped_scan = 1'b1;
            default: dropped_scan = 1'b0;
        endcase
        if (raw == bkrb_pkg::KEY_E0_PLAIN) return x;
        if (ch == bkrb_pkg::CH_EXT) begin
            if (sc == bkrb_pkg::SC_ALT_AT) x.key = bkrb_pkg::KEY_E0_PLAIN;
            else if (sc >= bkrb_pkg::SC_DITCH_MIN) x.ok = 1'b0;
            else x.key = {sc, 8'h00};
        end else if (ch == 8'h00 && dropped_scan) begin
            x.ok = 1'b0;
        end else if (raw == bkrb_pkg::KEY_KP_SLASH) begin
            x.key = bkrb_pkg::KEY_KP_SLASH_OLD;
        end else if (raw == bkrb_pkg::KEY_KP_ENTER || raw == bkrb_pkg::KEY_KP_CTL_ENTER) begin
            x.key = {bkrb_pkg::SC_ENTER, ch};
        end else if (sc >= bkrb_pkg::SC_DITCH_MIN) begin
            x.ok = 1'b0;
        end
        return x;
    endfunction

    // advance the shadow ring by one service call and return its answer
    function automatic kb_result_t kb_apply(logic [bkrb_pkg::ACT_W-1:0] act, bit ext,
                                            logic [bkrb_pkg::KEY_W-1:0] code);
        kb_result_t      r;
        bkrb_pkg::xlat_t x;
        int              n;
        int              steps;
        bit              hit;
        r = '0;
        if (act == bkrb_pkg::ACT_STORE) begin
            n = kb_next(kb_tail);
            if (n == kb_head) begin
                r.full_res = 1'b1;
            end else begin
                kb_words[kb_tail] = code;
                kb_written[kb_tail] = 1'b1;
                kb_tail = n;
            end
        end else if (act == bkrb_pkg::ACT_READ || act == bkrb_pkg::ACT_PEEK) begin
            steps = 0;
            hit = 1'b0;
            // drop ditched keys ahead of the head, bounded by the store depth
            while (!hit && kb_head != kb_tail && steps < KB_DEPTH) begin
                x = legacy_key(kb_words[kb_head]);
                if (ext || x.ok) begin
                    hit = 1'b1;
                    r.key_out = ext ? kb_words[kb_head] : x.key;
                end else begin
                    kb_head = kb_next(kb_head);
                    steps++;
                end
            end
            if (!hit) r.empty_res = 1'b1;
            else if (act == bkrb_pkg::ACT_READ) kb_head = kb_next(kb_head);
        end
        return r;
    endfunction

    // true when a read or peek now would only look at entries that hold a stored key
    function automatic bit walk_safe(bit ext);
        bkrb_pkg::xlat_t x;
        int              h;
        int              n;
        h = kb_head;
        n = 0;
        while (h != kb_tail && n < KB_DEPTH) begin
            if (!kb_written[h]) return 1'b0;
            x = legacy_key(kb_words[h]);
            if (ext || x.ok) return 1'b1;
            h = kb_next(h);
            n++;
        end
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [bkrb_pkg::KEY_W-1:0] pick_key();
        logic [bkrb_pkg::KEY_W-1:0] k;
        case ($urandom_range(0, 9))
            0, 1, 2: k = bkrb_pkg::KEY_W'($urandom_range(0, 16'hffff));
            3: k = {8'($urandom_range(0, 8'hff)), bkrb_pkg::CH_EXT};
            4: k = {8'($urandom_range(0, 8'h4f)), 8'h00};
            5: begin
                case ($urandom_range(0, 4))
                    0: k = bkrb_pkg::KEY_E0_PLAIN;
                    1: k = {bkrb_pkg::SC_ALT_AT, bkrb_pkg::CH_EXT};
                    2: k = bkrb_pkg::KEY_KP_SLASH;
                    3: k = bkrb_pkg::KEY_KP_ENTER;
                    default: k = bkrb_pkg::KEY_KP_CTL_ENTER;
                endcase
            end
            6: k = {8'($urandom_range(bkrb_pkg::SC_DITCH_MIN, 8'hff)),
                    8'($urandom_range(0, 8'hff))};
            default: k = {8'($urandom_range(2, 8'h58)), 8'($urandom_range(0, 8'hff))};
        endcase
        return k;
    endfunction

    task automatic queue_item(logic [bkrb_pkg::ACT_W-1:0] act, bit ext,
                              logic [bkrb_pkg::KEY_W-1:0] code);
        key_req_t q;
        q.action = act;
        q.extended = ext;
        q.key_code = code;
        key_reqs.push_back(q);
        answers_due.push_back(kb_apply(act, ext, code));
    endtask

    task automatic wait_drained();
        while (answers_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [bkrb_pkg::CFG_IDX_W-1:0] idx,
                             logic [bkrb_pkg::CFG_DATA_W-1:0] val);
        if (idx == bkrb_pkg::CFG_REG_START) kb_start = int'(val[bkrb_pkg::BUF_START_W-1:0]);
        else kb_end = int'(val);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // bursts of stores and of reads so the ring fills up and drains; some noise mixed in
    task automatic run_phase(logic [bkrb_pkg::CFG_DATA_W-1:0] st,
                             logic [bkrb_pkg::CFG_DATA_W-1:0] en, int n, bit quiet);
        logic [bkrb_pkg::ACT_W-1:0] act;
        bit                         ext;
        int                         made;
        int                         burst;
        int                         mode;
        wait_drained();
        calm = quiet;
        cfg_write(bkrb_pkg::CFG_REG_START, st);
        cfg_write(bkrb_pkg::CFG_REG_END, en);
        made = 0;
        while (made < n) begin
            burst = $urandom_range(1, 12);
            mode = $urandom_range(0, 9);
            for (int j = 0; j < burst && made < n; j++) begin
                ext = ($urandom_range(0, 3) == 0);
                if (mode < 4) begin
                    act = bkrb_pkg::ACT_STORE;
                end else if (mode < 8) begin
                    act = ($urandom_range(0, 2) == 0) ? bkrb_pkg::ACT_PEEK : bkrb_pkg::ACT_READ;
                end else if (mode == 8) begin
                    act = ($urandom_range(0, 1) == 0) ? bkrb_pkg::ACT_STORE : bkrb_pkg::ACT_READ;
                end else begin
                    act = bkrb_pkg::ACT_W'($urandom_range(0, 3));
                end
                if ((act == bkrb_pkg::ACT_READ || act == bkrb_pkg::ACT_PEEK) && !walk_safe(ext))
                    act = bkrb_pkg::ACT_STORE;
                queue_item(act, ext, pick_key());
                if (act != bkrb_pkg::ACT_NONE) made++;
            end
        end
    endtask

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left <= 0;
        end else if (s_valid && !in_taken) begin
            // hold the item until it is taken
        end else if (gap_left > 0) begin
            s_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (key_reqs.size() > 0) begin
            key_req_t q;
            q = key_reqs.pop_front();
            s_action <= q.action;
            s_extended <= q.extended;
            s_key_code <= q.key_code;
            s_valid <= 1'b1;
            gap_left <= pick_gap();
        end else begin
            s_valid <= 1'b0;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
        end
    end

    always @(posedge aclk) begin
        in_taken <= aresetn && s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            if (answers_due.size() == 0) begin
                if (mism < 10)
                    $display("result %0d: unexpected, key %h empty %b full %b",
                             results_seen, m_key_out, m_empty_res, m_full_res);
                mism++;
            end else begin
                kb_result_t want;
                want = answers_due.pop_front();
                if (m_key_out !== want.key_out || m_empty_res !== want.empty_res ||
                    m_full_res !== want.full_res) begin
                    if (mism < 10)
                        $display("result %0d: want key %h empty %b full %b, got key %h empty %b full %b",
                                 results_seen, want.key_out, want.empty_res, want.full_res,
                                 m_key_out, m_empty_res, m_full_res);
                    mism++;
                end
            end
            results_seen++;
        end
    end

    initial begin
        #(10_000_000);
        $display("tb_bios_keyboard_ring_buffer: errors");
        $finish;
    end

    initial begin
        for (int i = 0; i < KB_DEPTH; i++) begin
            kb_words[i] = '0;
            kb_written[i] = 1'b0;
        end
        kb_start = 0;
        kb_end = int'(bkrb_pkg::BUF_END_RST);
        kb_head = 0;
        kb_tail = 0;
        aresetn = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty ring, unused action
        queue_item(bkrb_pkg::ACT_READ, 1'b0, 16'h0000);
        queue_item(bkrb_pkg::ACT_PEEK, 1'b1, 16'hffff);
        queue_item(bkrb_pkg::ACT_NONE, 1'b1, 16'hffff);
        // eight keys that the translation drops
        queue_item(bkrb_pkg::ACT_STORE, 1'b0, 16'h0100);
        queue_item(bkrb_pkg::ACT_STORE, 1'b0, 16'h1c00);
        queue_item(bkrb_pkg::ACT_STORE, 1'b1, 16'h4e00);
        queue_item(bkrb_pkg::ACT_STORE, 1'b0, 16'h85e0);
        queue_item(bkrb_pkg::ACT_STORE, 1'b0, 16'hffe0);
        queue_item(bkrb_pkg::ACT_STORE, 1'b0, 16'h8561);
        queue_item(bkrb_pkg::ACT_STORE, 1'b0, 16'hffff);
        queue_item(bkrb_pkg::ACT_STORE, 1'b0, 16'h4a00);
        // shrink the ring so the tail falls outside: the skip walk hits its bound
        wait_drained();
        cfg_write(bkrb_pkg::CFG_REG_END, 7'd8);
        queue_item(bkrb_pkg::ACT_PEEK, 1'b0, 16'h0000);
        queue_item(bkrb_pkg::ACT_READ, 1'b1, 16'h0000);
        wait_drained();
        cfg_write(bkrb_pkg::CFG_REG_END, bkrb_pkg::CFG_DATA_W'(bkrb_pkg::BUF_END_RST));
        // every translation rule, then fill to full
        queue_item(bkrb_pkg::ACT_STORE, 1'b0, bkrb_pkg::KEY_E0_PLAIN);
        queue_item(bkrb_pkg::ACT_STORE, 1'b0, {bkrb_pkg::SC_ALT_AT, bkrb_pkg::CH_EXT});
        queue_item(bkrb_pkg::ACT_STORE, 1'b0, 16'h47e0);
        queue_item(bkrb_pkg::ACT_STORE, 1'b0, bkrb_pkg::KEY_KP_SLASH);
        queue_item(bkrb_pkg::ACT_STORE, 1'b0, bkrb_pkg::KEY_KP_ENTER);
        queue_item(bkrb_pkg::ACT_STORE, 1'b0, bkrb_pkg::KEY_KP_CTL_ENTER);
        queue_item(bkrb_pkg::ACT_STORE, 1'b0, 16'h1e61);
        queue_item(bkrb_pkg::ACT_STORE, 1'b0, 16'h0000);
        queue_item(bkrb_pkg::ACT_STORE, 1'b1, 16'h1234);
        // peek drops the ditched keys ahead of the head
        queue_item(bkrb_pkg::ACT_PEEK, 1'b0, 16'h0000);
        for (int i = 0; i < 8; i++) queue_item(bkrb_pkg::ACT_READ, (i == 5), 16'h0000);
        queue_item(bkrb_pkg::ACT_READ, 1'b0, 16'h0000);

        run_phase(7'd0, 7'd64, 70, 1'b0);
        run_phase(7'd63, 7'd64, 55, 1'b0);
        run_phase(7'd0, 7'd1, 45, 1'b1);
        run_phase(7'd20, 7'd36, 65, 1'b0);
        run_phase(7'd48, 7'd60, 60, 1'b0);
        run_phase(7'd7, 7'd3, 55, 1'b0);
        run_phase(7'd0, 7'd16, 70, 1'b1);

        wait_drained();
        repeat (200) @(posedge aclk);
        if (mism == 0 && answers_due.size() == 0) begin
            $display("tb_bios_keyboard_ring_buffer: clean");
        end else begin
            $display("tb_bios_keyboard_ring_buffer: errors");
        end
        $finish;
    end
endmodule
